[rtl/core/skt_pkg.sv]
// Shared package for the sorted key table: field widths, codes, and the
// command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package skt_pkg;

	// Default table depth
	localparam int DEPTH_DEF = 64;

	// Item field widths
	localparam int ACTION_W  = 2;
	localparam int KEY_W     = 64;
	localparam int PAYLOAD_W = 64;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 6;
	localparam int COUNT_W   = 7;

	// Stream data widths, padded to whole bytes
	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 80;
	localparam int M_PAD_W   = M_TDATA_W - POS_W - PAYLOAD_W - COUNT_W;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	// Entry pointer operations
	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_FILL,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	// Read address selection relative to the pointer
	typedef enum logic [1:0] {
		RD_PTR,
		RD_M1,
		RD_P1
	} rd_sel_t;

	// Entry write at the pointer
	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT,
		WR_NEW
	} wr_op_t;

	// Fill count update
	typedef enum logic [1:0] {
		FILL_HOLD,
		FILL_INC,
		FILL_DEC
	} fill_op_t;

	// Result staging update
	typedef enum logic [2:0] {
		RS_HOLD,
		RS_CLEAR,
		RS_NOT_FOUND,
		RS_FULL,
		RS_POS,
		RS_HIT
	} res_op_t;

	typedef struct packed {
		logic     load;
		ptr_op_t  ptr_op;
		rd_sel_t  rd_sel;
		wr_op_t   wr_op;
		fill_op_t fill_op;
		res_op_t  res_op;
		logic     out_load;
	} skt_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                ptr_zero;
		logic                ptr_at_fill;
		logic                ptr_last;
		logic                full;
		logic                key_eq;
		logic                key_gt;
		logic                out_free;
	} skt_sts_t;

endpackage

[rtl/core/skt_dpath.sv]
// Datapath of the sorted key table: entry memories, pointer, fill count,
// result staging and output register. Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_dpath #(
	parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  skt_pkg::skt_cmd_t                 cmd,
	output skt_pkg::skt_sts_t                 sts,
	input  logic [skt_pkg::ACTION_W-1:0]      in_action,
	input  logic [skt_pkg::S_TDATA_W-1:0]     in_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [skt_pkg::STATUS_W-1:0]      out_status,
	output logic [skt_pkg::M_TDATA_W-1:0]     out_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Entry memories
	logic [skt_pkg::KEY_W-1:0]     key_mem [DEPTH];
	logic [skt_pkg::PAYLOAD_W-1:0] pay_mem [DEPTH];

	// Held item
	logic [skt_pkg::ACTION_W-1:0]  action_q;
	logic [skt_pkg::KEY_W-1:0]     key_q;
	logic [skt_pkg::PAYLOAD_W-1:0] payload_q;

	logic [CW-1:0] ptr_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] ptr_m1;
	logic [CW-1:0] ptr_p1;

	logic [AW-1:0]                 rd_addr;
	logic [AW-1:0]                 wr_addr;
	logic                          wr_en;
	logic [skt_pkg::KEY_W-1:0]     wr_key;
	logic [skt_pkg::PAYLOAD_W-1:0] wr_pay;
	logic [skt_pkg::KEY_W-1:0]     rd_key_q;
	logic [skt_pkg::PAYLOAD_W-1:0] rd_pay_q;

	// Result staging
	logic [skt_pkg::STATUS_W-1:0]  res_status_q;
	logic [AW-1:0]                 res_pos_q;
	logic [skt_pkg::PAYLOAD_W-1:0] res_found_q;

	// Output register
	logic                          out_valid_q;
	logic [skt_pkg::STATUS_W-1:0]  out_status_q;
	logic [skt_pkg::POS_W-1:0]     out_pos_q;
	logic [skt_pkg::PAYLOAD_W-1:0] out_found_q;
	logic [skt_pkg::COUNT_W-1:0]   out_count_q;

	logic [AW+skt_pkg::POS_W-1:0]   pos_ext;
	logic [CW+skt_pkg::COUNT_W-1:0] count_ext;

	assign ptr_m1 = ptr_q - CW'(1);
	assign ptr_p1 = ptr_q + CW'(1);

	// Select read address around the pointer
	always_comb begin
		case (cmd.rd_sel)
			skt_pkg::RD_PTR: rd_addr = ptr_q[AW-1:0];
			skt_pkg::RD_M1:  rd_addr = ptr_m1[AW-1:0];
			skt_pkg::RD_P1:  rd_addr = ptr_p1[AW-1:0];
			default:         rd_addr = ptr_q[AW-1:0];
		endcase
	end

	// Write at the pointer: either the entry just read or the new one
	assign wr_addr = ptr_q[AW-1:0];
	assign wr_en   = (cmd.wr_op != skt_pkg::WR_NONE);
	assign wr_key  = (cmd.wr_op == skt_pkg::WR_SHIFT) ? rd_key_q : key_q;
	assign wr_pay  = (cmd.wr_op == skt_pkg::WR_SHIFT) ? rd_pay_q : payload_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_pay;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_pay_q <= pay_mem[rd_addr];
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= in_action;
			key_q     <= in_data[skt_pkg::KEY_W-1:0];
			payload_q <= in_data[skt_pkg::KEY_W +: skt_pkg::PAYLOAD_W];
		end
	end

	// Advance pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else begin
			case (cmd.ptr_op)
				skt_pkg::PTR_HOLD: ptr_q <= ptr_q;
				skt_pkg::PTR_ZERO: ptr_q <= '0;
				skt_pkg::PTR_FILL: ptr_q <= fill_q;
				skt_pkg::PTR_INC:  ptr_q <= ptr_p1;
				skt_pkg::PTR_DEC:  ptr_q <= ptr_m1;
				default:           ptr_q <= ptr_q;
			endcase
			case (cmd.fill_op)
				skt_pkg::FILL_HOLD: fill_q <= fill_q;
				skt_pkg::FILL_INC:  fill_q <= fill_q + CW'(1);
				skt_pkg::FILL_DEC:  fill_q <= fill_q - CW'(1);
				default:            fill_q <= fill_q;
			endcase
		end
	end

	// Stage the result fields
	always_ff @(posedge clk) begin
		case (cmd.res_op)
			skt_pkg::RS_HOLD: begin
			end
			skt_pkg::RS_CLEAR: begin
				res_status_q <= skt_pkg::STATUS_DONE;
				res_pos_q    <= '0;
				res_found_q  <= '0;
			end
			skt_pkg::RS_NOT_FOUND: begin
				res_status_q <= skt_pkg::STATUS_NOT_FOUND;
				res_pos_q    <= '0;
				res_found_q  <= '0;
			end
			skt_pkg::RS_FULL: begin
				res_status_q <= skt_pkg::STATUS_FULL;
				res_pos_q    <= '0;
				res_found_q  <= '0;
			end
			skt_pkg::RS_POS: begin
				res_status_q <= skt_pkg::STATUS_DONE;
				res_pos_q    <= ptr_q[AW-1:0];
				res_found_q  <= '0;
			end
			skt_pkg::RS_HIT: begin
				res_status_q <= skt_pkg::STATUS_DONE;
				res_pos_q    <= ptr_q[AW-1:0];
				res_found_q  <= rd_pay_q;
			end
			default: begin
			end
		endcase
	end

	assign pos_ext   = {{skt_pkg::POS_W{1'b0}}, res_pos_q};
	assign count_ext = {{skt_pkg::COUNT_W{1'b0}}, fill_q};

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_pos_q    <= pos_ext[skt_pkg::POS_W-1:0];
			out_found_q  <= res_found_q;
			out_count_q  <= count_ext[skt_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = {{skt_pkg::M_PAD_W{1'b0}}, out_count_q, out_found_q, out_pos_q};

	// Status towards the controller
	assign sts.action      = action_q;
	assign sts.ptr_zero    = (ptr_q == '0);
	assign sts.ptr_at_fill = (ptr_q == fill_q);
	assign sts.ptr_last    = (ptr_p1 == fill_q);
	assign sts.full        = (fill_q == CW'(DEPTH));
	assign sts.key_eq      = (rd_key_q == key_q);
	assign sts.key_gt      = (rd_key_q > key_q);
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule

[rtl/core/skt_ctrl.sv]
// Controller of the sorted key table: sequences insert shifts, searches
// and remove shifts over the datapath. Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  skt_pkg::skt_sts_t sts,
	output skt_pkg::skt_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_READ,
		ST_INS_CMP,
		ST_SRCH_READ,
		ST_SRCH_CMP,
		ST_REM_READ,
		ST_REM_SHIFT,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.ptr_op  = skt_pkg::PTR_HOLD;
		cmd.rd_sel  = skt_pkg::RD_PTR;
		cmd.wr_op   = skt_pkg::WR_NONE;
		cmd.fill_op = skt_pkg::FILL_HOLD;
		cmd.res_op  = skt_pkg::RS_HOLD;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && ready_q) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.action == skt_pkg::ACT_INSERT) begin
					if (sts.full) begin
						cmd.res_op = skt_pkg::RS_FULL;
						state_d    = ST_FINISH;
					end else begin
						cmd.ptr_op = skt_pkg::PTR_FILL;
						state_d    = ST_INS_READ;
					end
				end else if (sts.action == skt_pkg::ACT_REMOVE ||
						sts.action == skt_pkg::ACT_LOOKUP) begin
					cmd.ptr_op = skt_pkg::PTR_ZERO;
					state_d    = ST_SRCH_READ;
				end else begin
					cmd.res_op = skt_pkg::RS_CLEAR;
					state_d    = ST_FINISH;
				end
			end
			// Walk down from the top, moving greater entries up one place
			ST_INS_READ: begin
				if (sts.ptr_zero) begin
					cmd.wr_op   = skt_pkg::WR_NEW;
					cmd.res_op  = skt_pkg::RS_POS;
					cmd.fill_op = skt_pkg::FILL_INC;
					state_d     = ST_FINISH;
				end else begin
					cmd.rd_sel = skt_pkg::RD_M1;
					state_d    = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (sts.key_gt) begin
					cmd.wr_op  = skt_pkg::WR_SHIFT;
					cmd.ptr_op = skt_pkg::PTR_DEC;
					state_d    = ST_INS_READ;
				end else begin
					cmd.wr_op   = skt_pkg::WR_NEW;
					cmd.res_op  = skt_pkg::RS_POS;
					cmd.fill_op = skt_pkg::FILL_INC;
					state_d     = ST_FINISH;
				end
			end
			// Scan up for the first matching key; stop early past it
			ST_SRCH_READ: begin
				if (sts.ptr_at_fill) begin
					cmd.res_op = skt_pkg::RS_NOT_FOUND;
					state_d    = ST_FINISH;
				end else begin
					cmd.rd_sel = skt_pkg::RD_PTR;
					state_d    = ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				if (sts.key_eq) begin
					cmd.res_op = skt_pkg::RS_HIT;
					if (sts.action == skt_pkg::ACT_REMOVE) begin
						state_d = ST_REM_READ;
					end else begin
						state_d = ST_FINISH;
					end
				end else if (sts.key_gt) begin
					cmd.res_op = skt_pkg::RS_NOT_FOUND;
					state_d    = ST_FINISH;
				end else begin
					cmd.ptr_op = skt_pkg::PTR_INC;
					state_d    = ST_SRCH_READ;
				end
			end
			// Close the gap by moving later entries down one place
			ST_REM_READ: begin
				if (sts.ptr_last) begin
					cmd.fill_op = skt_pkg::FILL_DEC;
					state_d     = ST_FINISH;
				end else begin
					cmd.rd_sel = skt_pkg::RD_P1;
					state_d    = ST_REM_SHIFT;
				end
			end
			ST_REM_SHIFT: begin
				cmd.wr_op  = skt_pkg::WR_SHIFT;
				cmd.ptr_op = skt_pkg::PTR_INC;
				state_d    = ST_REM_READ;
			end
			// Hand the result over once the output register is free
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and the registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == ST_IDLE);
		end
	end

	assign in_ready = ready_q;

endmodule

[rtl/core/sorted_key_table_unit.sv]
// Sorted key table: one item at a time. A full-table insert or an unused action goes
// straight to its result; an insert walks down from the top, moving each greater entry
// up one place; a lookup scans up from index 0 until it hits, passes the key or runs
// past the last entry; a remove searches the same way, then moves later entries down.
// Each entry visited or moved takes a read step and then a compare or write step, set
// by the single read port of the entry memories. The next item can be accepted in the
// same cycle as the previous result is first offered. A result still waiting holds the
// next one in the controller. Reset clears the fill count and control state; the entry
// memories are not cleared. Top level; depends on skt_pkg, skt_ctrl and skt_dpath.
`timescale 1ns / 1ps

module sorted_key_table_unit #(
	parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input items
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [skt_pkg::S_TDATA_W-1:0] s_axis_tdata,  // key, payload
	input  logic [skt_pkg::ACTION_W-1:0]  s_axis_tuser,  // action
	// Result items
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [skt_pkg::M_TDATA_W-1:0] m_axis_tdata,  // position, found_payload, entry_count
	output logic [skt_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);

	skt_pkg::skt_cmd_t cmd;
	skt_pkg::skt_sts_t sts;

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	skt_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_action  (s_axis_tuser),
		.in_data    (s_axis_tdata),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (m_axis_tuser),
		.out_data   (m_axis_tdata)
	);

endmodule

[tb/tb_sorted_key_table_unit.sv]
// Self-checking testbench for sorted_key_table_unit: keeps a shadow copy of the
// sorted table, predicts one result item per input item and checks them in order.
// Depends on skt_pkg and the sorted_key_table_unit RTL.
`timescale 1ns / 1ps

module tb_sorted_key_table_unit;
	import skt_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 150;
	localparam int ITEM_TARGET  = 1250;
	localparam int POOL_SIZE    = 24;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [POS_W-1:0]     position;
		logic [PAYLOAD_W-1:0] found_payload;
		logic [COUNT_W-1:0]   entry_count;
	} reply_t;

	typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_t;

	// Shadow of the sorted table plus the queue of replies still owed by the block
	class sorted_table_tracker;
		logic [KEY_W-1:0]     keys[DEPTH_DEF];
		logic [PAYLOAD_W-1:0] payloads[DEPTH_DEF];
		int                   fill;
		reply_t               expected_replies[$];
		int                   mismatch_count;

		function new();
			fill = 0;
			mismatch_count = 0;
		endfunction

		// Apply an accepted item to the shadow table and queue its reply
		function void note_request(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k,
				logic [PAYLOAD_W-1:0] p);
			reply_t r;
			int     j;
			int     hit;
			r = '0;
			hit = -1;
			if (act == ACT_INSERT) begin
				if (fill >= DEPTH_DEF) begin
					r.status = STATUS_FULL;
				end else begin
					// shift greater keys up; equal keys stay ahead of the new one
					j = fill;
					while (j > 0 && keys[j-1] > k) begin
						keys[j] = keys[j-1];
						payloads[j] = payloads[j-1];
						j--;
					end
					keys[j] = k;
					payloads[j] = p;
					fill++;
					r.status = STATUS_DONE;
					r.position = POS_W'(j);
				end
			end else if (act == ACT_REMOVE || act == ACT_LOOKUP) begin
				for (j = 0; j < fill && hit < 0; j++) begin
					if (keys[j] == k)
						hit = j;
				end
				if (hit < 0) begin
					r.status = STATUS_NOT_FOUND;
				end else begin
					r.position = POS_W'(hit);
					r.found_payload = payloads[hit];
					if (act == ACT_REMOVE) begin
						// close the gap left by the removed entry
						for (j = hit; j + 1 < fill; j++) begin
							keys[j] = keys[j+1];
							payloads[j] = payloads[j+1];
						end
						fill--;
					end
				end
			end
			r.entry_count = COUNT_W'(fill);
			expected_replies.push_back(r);
		endfunction

		// Compare a result item with the oldest outstanding reply
		function void check_reply(reply_t got);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$error("result item with none outstanding: status %0d position %0d count %0d",
					got.status, got.position, got.entry_count);
				mismatch_count++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, got.status);
				mismatch_count++;
			end
			if (got.position !== want.position) begin
				$error("position mismatch: expected %0d, actual %0d",
					want.position, got.position);
				mismatch_count++;
			end
			if (got.found_payload !== want.found_payload) begin
				$error("found_payload mismatch: expected %h, actual %h",
					want.found_payload, got.found_payload);
				mismatch_count++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count mismatch: expected %0d, actual %0d",
					want.entry_count, got.entry_count);
				mismatch_count++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic [ACTION_W-1:0]   s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;

	sorted_table_tracker   tracker;
	logic [KEY_W-1:0]      key_pool[POOL_SIZE];
	int                    items_sent;
	int                    replies_seen;
	int                    stall_cycles;
	bit                    send_burst;
	bit                    recv_burst;

	sorted_key_table_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Pack a name into a key: first character most significant, zero padded
	function automatic logic [KEY_W-1:0] pack_name(string s);
		logic [KEY_W-1:0] v;
		v = '0;
		for (int i = 0; i < 8; i++)
			v = {v[KEY_W-9:0], (i < s.len()) ? s[i] : 8'h00};
		return v;
	endfunction

	// Offer one item after a random gap and note it once accepted
	task automatic send_request(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k,
			logic [PAYLOAD_W-1:0] p);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {p, k};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_request(act, k, p);
		items_sent++;
	endtask

	// Hold the sender until every outstanding reply has come back
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.expected_replies.size() != 0);
	endtask

	// Draw one item whose action mix depends on the phase
	task automatic send_random(traffic_mix_t mix);
		int                   roll;
		int                   insert_pct;
		logic [ACTION_W-1:0]  act;
		logic [KEY_W-1:0]     k;
		insert_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_BALANCED) ? 45 : 15;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			act = ACT_UNUSED;
		else if (roll < 3 + insert_pct)
			act = ACT_INSERT;
		else if ($urandom_range(0, 2) == 0)
			act = ACT_LOOKUP;
		else
			act = ACT_REMOVE;
		// favour keys already held so removes and lookups mostly hit
		roll = $urandom_range(0, 99);
		if (act != ACT_INSERT && roll < 50 && tracker.fill > 0)
			k = tracker.keys[$urandom_range(0, tracker.fill - 1)];
		else if (roll < 85)
			k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			k = rand64();
		send_request(act, k, rand64());
	endtask

	// Stimulus
	initial begin
		traffic_mix_t mix;
		int           phase_len;
		int           phase_no;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= ACT_INSERT;
		arst_n        <= 1'b0;
		items_sent = 0;
		send_burst = 1'b0;
		tracker = new();
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = pack_name("ALICE");
		key_pool[3] = pack_name("AL");
		key_pool[4] = pack_name("ALICEBOB");
		key_pool[5] = pack_name("BOB");
		key_pool[6] = pack_name("ZOE");
		key_pool[7] = pack_name("A");
		for (int i = 8; i < POOL_SIZE; i++)
			key_pool[i] = rand64();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, duplicates, prefixes, misses, unused code
		send_request(ACT_LOOKUP, pack_name("EMPTY"), rand64());
		send_request(ACT_REMOVE, pack_name("EMPTY"), rand64());
		send_request(ACT_UNUSED, rand64(), rand64());
		send_request(ACT_INSERT, '1, '1);
		send_request(ACT_INSERT, '0, '0);
		send_request(ACT_INSERT, pack_name("ALICE"), rand64());
		send_request(ACT_INSERT, pack_name("ALICE"), rand64());
		send_request(ACT_INSERT, pack_name("AL"), rand64());
		send_request(ACT_INSERT, pack_name("ALICEBOB"), rand64());
		send_request(ACT_LOOKUP, pack_name("ALICE"), rand64());
		send_request(ACT_LOOKUP, '1, rand64());
		send_request(ACT_LOOKUP, '0, rand64());
		send_request(ACT_LOOKUP, pack_name("BOB"), rand64());
		send_request(ACT_UNUSED, '1, '1);
		send_request(ACT_REMOVE, pack_name("ALICE"), rand64());
		send_request(ACT_LOOKUP, pack_name("ALICE"), rand64());
		send_request(ACT_REMOVE, '1, rand64());
		send_request(ACT_REMOVE, '0, rand64());
		send_request(ACT_REMOVE, pack_name("BOB"), rand64());
		send_request(ACT_REMOVE, pack_name("ALICE"), rand64());
		send_request(ACT_LOOKUP, pack_name("ALICE"), rand64());
		hold_until_drained();

		// Random phases: fill-heavy, churn, drain-heavy
		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase_no % 4)
				0: mix = MIX_FILL;
				2: mix = MIX_DRAIN;
				default: mix = MIX_BALANCED;
			endcase
			send_burst = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(120, 200);
			for (int n = 0; n < phase_len && items_sent < ITEM_TARGET; n++)
				send_random(mix);
			if ($urandom_range(0, 1) == 0)
				hold_until_drained();
			phase_no++;
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.expected_replies.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Receive result items with random stalls and check each one
	initial begin
		reply_t got;
		int     gap;
		replies_seen = 0;
		recv_burst = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = recv_burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.status        = m_axis_tuser;
			got.position      = m_axis_tdata[POS_W-1:0];
			got.found_payload = m_axis_tdata[POS_W +: PAYLOAD_W];
			got.entry_count   = m_axis_tdata[POS_W+PAYLOAD_W +: COUNT_W];
			tracker.check_reply(got);
			replies_seen++;
			if (replies_seen % 90 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog: end the run when no item moves for too long
	initial stall_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

[filelist.f]
rtl/core/skt_pkg.sv
rtl/core/skt_dpath.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_table_unit.sv
tb/tb_sorted_key_table_unit.sv
